// ===== rtl/core/htd_pkg.sv =====
// ----------------------------------------------------------------------------
// htd_pkg
// shared codes, command and result types of the tree-walk decoder
// ----------------------------------------------------------------------------
package htd_pkg;

    // input op codes
    localparam logic [1:0] OP_TREE = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    // result kinds
    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_END    = 1'b1;

    // end status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_CORRUPT = 1'b1;

    // tree byte that announces a leaf, ascii '1'
    localparam logic [7:0] LEAF_MARK = 8'h31;

    // command classes handed from front to back
    typedef enum logic [1:0] {
        CMD_TREE = 2'd0,
        CMD_DATA = 2'd1,
        CMD_END  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic       kind;
        logic [7:0] symbol;
        logic       status;
        logic       last;
    } t_result;

endpackage

// ===== rtl/core/huffman_tree_decoder_unit.sv =====
// sequence: a tree word passes the alloc and link states after the queue (a leaf symbol
//   or ignored word is taken in idle), a data word runs pop, a step per bit and a closing
//   step, fewer steps once the symbol count is reached, held longer under output stalls;
//   an end word is taken in idle; results leave through an output register
// a data word is walked to its end before the next word is taken, one child-table read per bit
// reset: synchronous, active low; clears control state, tables stay undefined, no clear pass
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit
// loads a pre-order code tree, then walks it bit by bit to decode symbols
// ----------------------------------------------------------------------------
module huffman_tree_decoder_unit #(
    parameter int NODES       = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: symbol count
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_symbol,
    output logic        o_status,
    output logic        o_last
);

    // command queue between front and back
    htd_pkg::t_cmd    cmd;
    logic             cmd_valid;
    logic             cmd_pop;
    htd_pkg::t_result res;

    // front: accepts words, drops unknown ops, two-entry queue
    htd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // back: tree build, bit walk, held symbol for the last flag, output register
    htd_back #(
        .NODES       (NODES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (res),
        .o_res_valid (o_out_valid),
        .i_res_stall (i_out_stall)
    );

    // result fields onto their ports
    assign o_kind   = res.kind;
    assign o_symbol = res.symbol;
    assign o_status = res.status;
    assign o_last   = res.last;

endmodule

// ===== rtl/core/htd_front.sv =====
// ----------------------------------------------------------------------------
// htd_front
// accepts input words, classifies the op and queues commands for the back end
// ----------------------------------------------------------------------------
module htd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_op,
    input  logic [7:0]    i_data_byte,
    output htd_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);

    htd_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;
    logic [1:0]    n_count;
    logic          accept;
    logic          keep;
    logic          cmd_ok;
    htd_pkg::t_cmd cmd;

    // op 3 is accepted and dropped
    always_comb begin
        cmd_ok    = 1'b1;
        cmd.data  = i_data_byte;
        cmd.kind  = htd_pkg::CMD_TREE;
        unique case (i_op)
            htd_pkg::OP_TREE: cmd.kind = htd_pkg::CMD_TREE;
            htd_pkg::OP_DATA: cmd.kind = htd_pkg::CMD_DATA;
            htd_pkg::OP_END:  cmd.kind = htd_pkg::CMD_END;
            default:          cmd_ok   = 1'b0;
        endcase
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign accept      = i_in_valid && !o_in_stall;
    assign keep        = accept && cmd_ok;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign n_count     = r_count + {1'b0, keep} - {1'b0, i_cmd_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (keep) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

// ===== rtl/core/htd_back.sv =====
// ----------------------------------------------------------------------------
// htd_back
// builds the child-link tables from the tree bytes and walks them per bit
// ----------------------------------------------------------------------------
module htd_back #(
    parameter int NODES       = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  htd_pkg::t_cmd    i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_pop,
    input  logic             i_cfg_we,
    input  logic [30:0]      i_cfg_wdata,
    output htd_pkg::t_result o_res,
    output logic             o_res_valid,
    input  logic             i_res_stall
);

    localparam int IDX_W   = $clog2(NODES);
    localparam int CNT_W   = $clog2(NODES + 1);
    localparam int STK_W   = $clog2(STACK_DEPTH);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int LINK_W  = 9 + IDX_W;   // leaf, symbol, child index
    localparam int STKE_W  = IDX_W + 1;   // node index, left-set flag

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ALLOC = 5'b00010,
        S_LINK  = 5'b00100,
        S_WALK  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    // child link tables and parent stack
    logic [LINK_W-1:0] r_left_mem  [NODES];
    logic [LINK_W-1:0] r_right_mem [NODES];
    logic [STKE_W-1:0] r_stk_mem   [STACK_DEPTH];
    logic [LINK_W-1:0] r_lt;
    logic [LINK_W-1:0] r_rt;
    logic [STKE_W-1:0] r_stk_rd;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic              r_expect, n_expect;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [30:0]       r_decoded, n_decoded;
    logic [30:0]       r_total;
    logic              r_root_leaf, n_root_leaf;
    logic [7:0]        r_root_sym, n_root_sym;
    logic              r_link_en, n_link_en;
    logic [IDX_W-1:0]  r_link_par, n_link_par;
    logic              r_link_right, n_link_right;
    logic [IDX_W-1:0]  r_new_idx, n_new_idx;
    logic              r_new_root, n_new_root;
    logic [7:0]        r_byte, n_byte;
    logic [2:0]        r_bit, n_bit;
    logic              r_hold_valid, n_hold_valid;
    logic [7:0]        r_hold_sym, n_hold_sym;
    logic              r_out_valid;
    htd_pkg::t_result  r_out;

    logic              lm_we, rm_we, sk_we, rd_en, sk_rd_en;
    logic [IDX_W-1:0]  lm_addr, rm_addr, rd_addr;
    logic [LINK_W-1:0] lm_wdata, rm_wdata, link_wdata, ent;
    logic [STK_W-1:0]  sk_addr;
    logic [STKE_W-1:0] sk_wdata;
    logic [SP_W-1:0]   sp_m1;
    logic              out_free, push, emit, can, leaf_byte, cnt_done;
    logic [7:0]        esym;
    logic [IDX_W-1:0]  nxt_cur, idx;
    htd_pkg::t_result  push_res;

    assign out_free  = !r_out_valid || !i_res_stall;
    assign sp_m1     = r_sp - SP_W'(1);
    assign idx       = r_cnt[IDX_W-1:0];
    assign leaf_byte = (r_byte == htd_pkg::LEAF_MARK);
    assign cnt_done  = (r_decoded >= r_total);
    assign ent       = r_byte[r_bit] ? r_rt : r_lt;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_sp         = r_sp;
        n_expect     = r_expect;
        n_cur        = r_cur;
        n_decoded    = r_decoded;
        n_root_leaf  = r_root_leaf;
        n_root_sym   = r_root_sym;
        n_link_en    = r_link_en;
        n_link_par   = r_link_par;
        n_link_right = r_link_right;
        n_new_idx    = r_new_idx;
        n_new_root   = r_new_root;
        n_byte       = r_byte;
        n_bit        = r_bit;
        n_hold_valid = r_hold_valid;
        n_hold_sym   = r_hold_sym;
        lm_we        = 1'b0;
        lm_addr      = r_link_par;
        lm_wdata     = '0;
        rm_we        = 1'b0;
        rm_addr      = r_link_par;
        rm_wdata     = '0;
        sk_we        = 1'b0;
        sk_addr      = sp_m1[STK_W-1:0];
        sk_wdata     = '0;
        rd_en        = 1'b0;
        rd_addr      = r_cur;
        sk_rd_en     = 1'b0;
        o_cmd_pop    = 1'b0;
        push         = 1'b0;
        push_res     = '0;
        emit         = 1'b0;
        esym         = 8'd0;
        nxt_cur      = '0;
        can          = 1'b0;
        link_wdata   = '0;

        unique case (r_state)
            S_IDLE: begin
                sk_rd_en = 1'b1;
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        htd_pkg::CMD_TREE: begin
                            o_cmd_pop = 1'b1;
                            if (r_expect) begin
                                // symbol of the last leaf: root shadow or parent link
                                n_expect   = 1'b0;
                                link_wdata = {1'b1, i_cmd.data, r_new_idx};
                                if (r_new_root) begin
                                    n_root_sym = i_cmd.data;
                                end else if (r_link_en) begin
                                    if (r_link_right) begin
                                        rm_we    = 1'b1;
                                        rm_wdata = link_wdata;
                                    end else begin
                                        lm_we    = 1'b1;
                                        lm_wdata = link_wdata;
                                    end
                                end
                            end else if (!((r_cnt == CNT_W'(NODES)) ||
                                           ((r_cnt != '0) && (r_sp == '0)))) begin
                                n_byte  = i_cmd.data;
                                n_state = S_ALLOC;
                            end
                        end
                        htd_pkg::CMD_DATA: begin
                            o_cmd_pop = 1'b1;
                            if (r_cnt != '0) begin
                                rd_en   = 1'b1;
                                n_byte  = i_cmd.data;
                                n_bit   = 3'd7;
                                n_state = S_WALK;
                            end
                        end
                        htd_pkg::CMD_END: begin
                            if (out_free) begin
                                o_cmd_pop       = 1'b1;
                                push            = 1'b1;
                                push_res.kind   = htd_pkg::KIND_END;
                                push_res.status = (r_decoded < r_total) ?
                                                  htd_pkg::ST_CORRUPT : htd_pkg::ST_OK;
                                push_res.last   = 1'b1;
                            end
                        end
                        default: o_cmd_pop = 1'b1;
                    endcase
                end
            end

            S_ALLOC: begin
                // new node, children point at the root
                lm_we      = 1'b1;
                lm_addr    = idx;
                rm_we      = 1'b1;
                rm_addr    = idx;
                n_cnt      = r_cnt + CNT_W'(1);
                n_new_idx  = idx;
                n_new_root = (r_cnt == '0);
                n_expect   = leaf_byte;
                if (r_cnt == '0) begin
                    n_root_leaf = leaf_byte;
                    n_root_sym  = 8'd0;
                end
                n_link_en  = (r_sp != '0);
                n_link_par = r_stk_rd[STKE_W-1:1];
                if (r_sp != '0) begin
                    if (!r_stk_rd[0]) begin
                        n_link_right = 1'b0;
                        sk_we        = 1'b1;
                        sk_wdata     = {r_stk_rd[STKE_W-1:1], 1'b1};
                    end else begin
                        n_link_right = 1'b1;
                        n_sp         = sp_m1;
                    end
                end
                n_state = S_LINK;
            end

            S_LINK: begin
                link_wdata = {leaf_byte, 8'd0, r_new_idx};
                if (r_link_en) begin
                    if (r_link_right) begin
                        rm_we    = 1'b1;
                        rm_wdata = link_wdata;
                    end else begin
                        lm_we    = 1'b1;
                        lm_wdata = link_wdata;
                    end
                end
                if (!leaf_byte && (r_sp < SP_W'(STACK_DEPTH))) begin
                    sk_we    = 1'b1;
                    sk_addr  = r_sp[STK_W-1:0];
                    sk_wdata = {r_new_idx, 1'b0};
                    n_sp     = r_sp + SP_W'(1);
                end
                n_state = S_IDLE;
            end

            S_WALK: begin
                if (cnt_done) begin
                    n_state = S_FLUSH;
                end else begin
                    if (r_root_leaf) begin
                        emit = 1'b1;
                        esym = r_root_sym;
                    end else if (ent[LINK_W-1]) begin
                        emit = 1'b1;
                        esym = ent[LINK_W-2 -: 8];
                    end else begin
                        nxt_cur = ent[IDX_W-1:0];
                    end
                    can = !(emit && r_hold_valid && !out_free);
                    if (can) begin
                        if (emit) begin
                            // previous symbol is known not to be last
                            if (r_hold_valid) begin
                                push            = 1'b1;
                                push_res.kind   = htd_pkg::KIND_SYMBOL;
                                push_res.symbol = r_hold_sym;
                            end
                            n_hold_valid = 1'b1;
                            n_hold_sym   = esym;
                            n_decoded    = r_decoded + 31'd1;
                        end
                        n_cur   = nxt_cur;
                        rd_en   = 1'b1;
                        rd_addr = nxt_cur;
                        if (r_bit == 3'd0) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_bit = r_bit - 3'd1;
                        end
                    end
                end
            end

            S_FLUSH: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    push_res.kind   = htd_pkg::KIND_SYMBOL;
                    push_res.symbol = r_hold_sym;
                    push_res.last   = 1'b1;
                    n_hold_valid    = 1'b0;
                    n_state         = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_sp         <= '0;
            r_expect     <= 1'b0;
            r_cur        <= '0;
            r_decoded    <= '0;
            r_total      <= '0;
            r_root_leaf  <= 1'b0;
            r_link_en    <= 1'b0;
            r_new_root   <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_sp         <= n_sp;
            r_expect     <= n_expect;
            r_cur        <= n_cur;
            r_decoded    <= n_decoded;
            r_root_leaf  <= n_root_leaf;
            r_link_en    <= n_link_en;
            r_new_root   <= n_new_root;
            r_hold_valid <= n_hold_valid;
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            if (out_free) begin
                r_out_valid <= push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_root_sym   <= n_root_sym;
        r_link_par   <= n_link_par;
        r_link_right <= n_link_right;
        r_new_idx    <= n_new_idx;
        r_byte       <= n_byte;
        r_bit        <= n_bit;
        r_hold_sym   <= n_hold_sym;
        if (push) begin
            r_out <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lm_we) begin
            r_left_mem[lm_addr] <= lm_wdata;
        end
        if (rd_en) begin
            r_lt <= r_left_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rm_we) begin
            r_right_mem[rm_addr] <= rm_wdata;
        end
        if (rd_en) begin
            r_rt <= r_right_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sk_we) begin
            r_stk_mem[sk_addr] <= sk_wdata;
        end
        if (sk_rd_en) begin
            r_stk_rd <= r_stk_mem[sp_m1[STK_W-1:0]];
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== rtl/core/htd_checker.sv =====
// ----------------------------------------------------------------------------
// htd_checker
// port-level checks on the result channel of the decoder
// ----------------------------------------------------------------------------
module htd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [30:0] i_cfg_wdata,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_op,
    input logic [7:0]  i_data_byte,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_kind,
    input logic [7:0]  o_symbol,
    input logic        o_status,
    input logic        o_last
);

    // end word always closes its item and carries no symbol
    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == htd_pkg::KIND_END) |-> o_last && (o_symbol == 8'd0))
        else $error("end word malformed");

    // symbol words carry no status
    a_sym_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == htd_pkg::KIND_SYMBOL) |-> (o_status == htd_pkg::ST_OK))
        else $error("symbol word with status set");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) && $stable(o_symbol)
            && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind huffman_tree_decoder_unit htd_checker u_htd_checker (.*);

// ===== verif/huffman_tree_decoder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder_checker
// mirrors tree loading and bit walking, and compares every result word
// ----------------------------------------------------------------------------
module huffman_tree_decoder_checker #(
    parameter int NODES       = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_symbol,
    input  logic        i_status,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int REPORT_CAP = 100;

    // mirror of the node table and the open-parent stack
    bit          node_is_leaf [NODES];
    logic [7:0]  node_symbol  [NODES];
    int          node_lchild  [NODES];
    int          node_rchild  [NODES];
    int          anc_node     [STACK_DEPTH];
    bit          anc_left_set [STACK_DEPTH];

    int          anc_depth;
    int          nodes_used;
    bit          symbol_due;
    int          walk_pos;
    int unsigned symbols_decoded;
    int unsigned symbol_target;
    int          mismatches = 0;
    int          reported   = 0;

    htd_pkg::t_result awaited_words [$];

    function automatic bit tree_closed();
        if (symbol_due) return 1'b0;
        if (nodes_used >= NODES) return 1'b1;
        return (nodes_used > 0) && (anc_depth == 0);
    endfunction

    function automatic void attach_node(bit leaf);
        int idx;
        int top;
        idx = nodes_used;
        nodes_used++;
        node_is_leaf[idx] = leaf;
        node_symbol[idx]  = 8'h00;
        node_lchild[idx]  = 0;
        node_rchild[idx]  = 0;
        if (anc_depth > 0) begin
            top = anc_depth - 1;
            if (!anc_left_set[top]) begin
                node_lchild[anc_node[top]] = idx;
                anc_left_set[top] = 1'b1;
            end else begin
                node_rchild[anc_node[top]] = idx;
                anc_depth--;
            end
        end
        // a full stack still links the node, it just cannot hold it open
        if (!leaf && anc_depth < STACK_DEPTH) begin
            anc_node[anc_depth]     = idx;
            anc_left_set[anc_depth] = 1'b0;
            anc_depth++;
        end
    endfunction

    function automatic void load_tree_byte(logic [7:0] b);
        if (symbol_due) begin
            node_symbol[nodes_used - 1] = b;
            symbol_due = 1'b0;
        end else if (!tree_closed()) begin
            attach_node(b == htd_pkg::LEAF_MARK);
            symbol_due = (b == htd_pkg::LEAF_MARK);
        end
    endfunction

    function automatic void decode_word(logic [1:0] op, logic [7:0] b);
        htd_pkg::t_result found [8];
        int               n;
        int               nxt;
        n = 0;
        if (op == htd_pkg::OP_TREE) begin
            load_tree_byte(b);
        end else if (op == htd_pkg::OP_END) begin
            awaited_words.push_back('{kind: htd_pkg::KIND_END, symbol: 8'h00,
                status: (symbols_decoded < symbol_target) ?
                        htd_pkg::ST_CORRUPT : htd_pkg::ST_OK,
                last: 1'b1});
        end else if (op == htd_pkg::OP_DATA && nodes_used != 0) begin
            for (int i = 7; i >= 0; i--) begin
                if (symbols_decoded >= symbol_target) break;
                // a leaf at the root emits on every bit
                if (node_is_leaf[0]) nxt = 0;
                else nxt = b[i] ? node_rchild[walk_pos] : node_lchild[walk_pos];
                if (node_is_leaf[nxt]) begin
                    found[n] = '{kind: htd_pkg::KIND_SYMBOL, symbol: node_symbol[nxt],
                        status: htd_pkg::ST_OK, last: 1'b0};
                    n++;
                    symbols_decoded++;
                    walk_pos = 0;
                end else begin
                    walk_pos = nxt;
                end
            end
            for (int k = 0; k < n; k++) begin
                found[k].last = (k == n - 1);
                awaited_words.push_back(found[k]);
            end
        end
    endfunction

    function automatic bit field_ok(string what, logic [7:0] want_v, logic [7:0] got_v);
        if (want_v === got_v) return 1'b1;
        if (reported < REPORT_CAP)
            $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
        reported++;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        htd_pkg::t_result want;
        if (!i_rst_n) begin
            anc_depth       = 0;
            nodes_used      = 0;
            symbol_due      = 1'b0;
            walk_pos        = 0;
            symbols_decoded = 0;
            symbol_target   = 0;
            awaited_words.delete();
        end else begin
            // results cannot come from a word taken at this same edge
            if (i_out_valid && !i_out_stall) begin
                if (awaited_words.size() == 0) begin
                    mismatches++;
                    if (reported < REPORT_CAP)
                        $display({"%0t: word expected none got kind %0h symbol %0h",
                                  " status %0h last %0h"},
                            $time, i_kind, i_symbol, i_status, i_last);
                    reported++;
                end else begin
                    want = awaited_words.pop_front();
                    if (!(field_ok("kind", 8'(want.kind), 8'(i_kind))
                          & field_ok("symbol", want.symbol, i_symbol)
                          & field_ok("status", 8'(want.status), 8'(i_status))
                          & field_ok("last", 8'(want.last), 8'(i_last))))
                        mismatches++;
                end
            end
            if (i_cfg_we) symbol_target = 32'(i_cfg_wdata);
            if (i_in_valid && !i_in_stall) decode_word(i_op, i_data_byte);
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_words.size();
    end

endmodule

// ===== verif/huffman_tree_decoder_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit_tb
// loads one code tree per run (lone leaf, stack-overflowing deep chain or a
// random full tree), probes partial trees, then streams data words under
// changing symbol counts with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module huffman_tree_decoder_unit_tb;

    localparam int          CYCLE_LIMIT    = 2_000_000;
    localparam int          RANDOM_WORDS   = 300;
    localparam int          SETTLE_CYCLES  = 48;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          DEEP_INTERNALS = 300;
    localparam int          DEEP_LEAVES    = 212;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [30:0] COUNT_MAX      = 31'h7FFF_FFFF;

    // which tree this run loads; only one tree fits between resets
    typedef enum int {
        SHAPE_LONE_LEAF,
        SHAPE_DEEP,
        SHAPE_RANDOM
    } t_shape;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [30:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_op;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_kind;
    logic [7:0]  o_symbol;
    logic        o_status;
    logic        o_last;

    int          fail_count;
    int          pending;
    int          cycles       = 0;
    int          symbols_seen = 0;
    int          stall_left   = 0;
    bit          in_quiet     = 1'b0;
    bit          out_quiet    = 1'b0;
    t_shape      shape;
    logic [7:0]  tree_q [$];

    huffman_tree_decoder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_symbol    (o_symbol),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    huffman_tree_decoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_data_byte  (i_data_byte),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_kind       (o_kind),
        .i_symbol     (o_symbol),
        .i_status     (o_status),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // decoded symbols so far, used to aim the symbol count near the current total
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall && o_kind == htd_pkg::KIND_SYMBOL)
            symbols_seen <= symbols_seen + 1;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 8);
        return $urandom_range(9, 30);
    endfunction

    // result side back-pressure, switched off in quiet phases
    always @(negedge i_clk) begin
        if (out_quiet) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = gap_len() - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // any tree byte except the leaf mark opens an internal node
    function automatic logic [7:0] internal_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == htd_pkg::LEAF_MARK);
        return v;
    endfunction

    // symbols lean toward the edges and the leaf mark itself
    function automatic logic [7:0] leaf_symbol();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return htd_pkg::LEAF_MARK;
        if (r == 1) return 8'h00;
        if (r == 2) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // the deep chain only reaches leaves after long runs of zero bits
    function automatic logic [7:0] pick_data();
        int         r;
        logic [7:0] v;
        r = $urandom_range(0, 15);
        v = 8'($urandom_range(0, 255));
        if (shape == SHAPE_DEEP) begin
            if (r < 11) return 8'h00;
            if (r < 15) return 8'h01 << $urandom_range(0, 7);
            return v;
        end
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return v;
    endfunction

    // called on a falling edge, returns on the falling edge after acceptance
    task automatic send_word(input logic [1:0] op, input logic [7:0] b);
        int gap;
        gap = (in_quiet || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // wait until every result is back, then let queued silent words finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [30:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int need;
        int internals;
        int cap;
        int probes;
        int rand_words;
        int burst;
        int r;
        int sel;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_op        = htd_pkg::OP_TREE;
        i_data_byte = 8'h00;
        i_out_stall = 1'b0;

        // pick and serialize this run's tree in pre-order
        r = $urandom_range(0, 7);
        shape = (r == 0) ? SHAPE_LONE_LEAF : (r == 1) ? SHAPE_DEEP : SHAPE_RANDOM;
        case (shape)
            SHAPE_LONE_LEAF: begin
                tree_q.push_back(htd_pkg::LEAF_MARK);
                tree_q.push_back(leaf_symbol());
            end
            SHAPE_DEEP: begin
                // nests past the parent stack, then fills the node table
                repeat (DEEP_INTERNALS) tree_q.push_back(internal_byte());
                repeat (DEEP_LEAVES) begin
                    tree_q.push_back(htd_pkg::LEAF_MARK);
                    tree_q.push_back(leaf_symbol());
                end
            end
            default: begin
                cap       = $urandom_range(2, 40);
                tree_q.push_back(internal_byte());
                internals = 1;
                need      = 2;
                while (need > 0) begin
                    if (internals < cap && $urandom_range(0, 99) < 52) begin
                        tree_q.push_back(internal_byte());
                        internals++;
                        need++;
                    end else begin
                        tree_q.push_back(htd_pkg::LEAF_MARK);
                        tree_q.push_back(leaf_symbol());
                        need--;
                    end
                end
            end
        endcase

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // count far out of reach: end reports a short stream
        write_count(COUNT_MAX);
        send_word(htd_pkg::OP_END, 8'h00);
        // nothing loaded yet, and an unused op: both silent
        send_word(htd_pkg::OP_DATA, 8'hFF);
        send_word(OP_UNUSED, 8'hA5);

        // walk partial trees, including a leaf still waiting for its symbol
        probes = (tree_q.size() < 4) ? tree_q.size() : 4;
        for (int i = 0; i < probes; i++) begin
            send_word(htd_pkg::OP_TREE, tree_q[i]);
            send_word(htd_pkg::OP_DATA, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : pick_data());
        end
        for (int i = probes; i < tree_q.size(); i++)
            send_word(htd_pkg::OP_TREE, tree_q[i]);

        // tree is closed, further tree bytes fall through
        send_word(htd_pkg::OP_TREE, htd_pkg::LEAF_MARK);
        send_word(htd_pkg::OP_TREE, 8'h00);

        send_word(htd_pkg::OP_DATA, 8'h00);
        send_word(htd_pkg::OP_DATA, 8'hFF);
        send_word(htd_pkg::OP_DATA, 8'h80);
        send_word(htd_pkg::OP_DATA, 8'h01);
        send_word(htd_pkg::OP_END, 8'hFF);

        // zero count: data words are dropped, end reports ok
        settle();
        write_count('0);
        send_word(htd_pkg::OP_DATA, 8'hFF);
        send_word(htd_pkg::OP_END, 8'h00);

        // count runs out partway through a data word
        settle();
        write_count(31'(symbols_seen + 3));
        send_word(htd_pkg::OP_DATA, 8'h00);
        send_word(htd_pkg::OP_DATA, 8'hFF);
        send_word(htd_pkg::OP_DATA, pick_data());
        send_word(htd_pkg::OP_END, 8'h00);

        // random phases, each with its own count and its own pressure
        rand_words = 0;
        while (rand_words < RANDOM_WORDS) begin
            settle();
            sel = $urandom_range(0, 9);
            if (sel == 0) write_count('0);
            else if (sel == 1) write_count(COUNT_MAX);
            else if (sel == 2) write_count(31'(symbols_seen));
            else if (sel == 3) write_count(31'($urandom()));
            else write_count(31'(symbols_seen + $urandom_range(1, 60)));
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);

            burst = $urandom_range(10, 50);
            repeat (burst) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    send_word(htd_pkg::OP_DATA, pick_data());
                    rand_words++;
                end else if (r < 88) begin
                    send_word(htd_pkg::OP_END, 8'($urandom_range(0, 255)));
                    rand_words++;
                end else if (r < 94) begin
                    send_word(htd_pkg::OP_TREE, 8'($urandom_range(0, 255)));
                end else begin
                    send_word(OP_UNUSED, 8'($urandom_range(0, 255)));
                end
            end
        end

        // drain, then watch a little longer for stray words
        i_in_valid <= 1'b0;
        out_quiet = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/htd_pkg.sv
rtl/core/htd_front.sv
rtl/core/htd_back.sv
rtl/core/huffman_tree_decoder_unit.sv
rtl/core/htd_checker.sv
verif/huffman_tree_decoder_checker.sv
verif/huffman_tree_decoder_unit_tb.sv
